FILE: rtl/core/sros_pkg.sv
// shared types and constants for the sonar ring obstacle steering block
package sros_pkg;

    localparam int NUM_LANES = 8;
    localparam logic [15:0] NONE_MM = 16'hFFFF;

    // register indexes
    localparam logic [2:0] REG_CRUISE = 3'd0;
    localparam logic [2:0] REG_SLOW = 3'd1;
    localparam logic [2:0] REG_STOP = 3'd2;
    localparam logic [2:0] REG_NEAR = 3'd3;
    localparam logic [2:0] REG_MARGIN = 3'd4;
    localparam logic [2:0] REG_TURN = 3'd5;

    // per-lane geometry
    typedef struct packed {
        logic [7:0]  fwd_off;
        logic [7:0]  lat_off;
        logic [16:0] sin_q16;
        logic [16:0] cos_q16;
        logic        right_side;
    } lane_geom_t;

    // what a lane reports to the merge
    typedef struct packed {
        logic        in_corr;
        logic [15:0] front;
        logic        side_ok;
        logic        is_right;
        logic [15:0] side_mm;
    } lane_res_t;

    typedef struct packed {
        logic [11:0] cruise_speed;
        logic [11:0] slow_zone_mm;
        logic [10:0] stop_offset_mm;
        logic [11:0] side_near_mm;
        logic [9:0]  side_margin_mm;
        logic [10:0] turn_rate;
    } cfg_t;

    function automatic lane_geom_t lane_geom(input int idx);
        lane_geom_t g;
        case (idx)
            0, 7: g = '{8'd115, 8'd130, 17'd65536, 17'd0, 1'b0};
            1, 6: g = '{8'd155, 8'd115, 17'd50203, 17'd42126, 1'b0};
            2, 5: g = '{8'd190, 8'd80, 17'd32768, 17'd56756, 1'b0};
            default: g = '{8'd210, 8'd25, 17'd11380, 17'd64540, 1'b0};
        endcase
        g.right_side = (idx >= NUM_LANES / 2);
        return g;
    endfunction

endpackage

FILE: rtl/core/sros_isqrt.sv
// pipelined integer square root, two result bits per stage
module sros_isqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [49:0] radicand,
    input  logic [16:0] tag_in,
    output logic        out_valid,
    output logic [24:0] root,
    output logic [16:0] tag_out
);
    localparam int STAGES = 13;
    localparam int STEPS = 2;

    // partial remainder on top, radicand bits still to bring down below
    logic [78:0] rem_reg [STAGES+1];
    logic [25:0] res_reg [STAGES+1];
    logic [16:0] tag_reg [STAGES+1];
    logic        vld_reg [STAGES+1];

    assign rem_reg[0] = {27'd0, 2'b00, radicand};
    assign res_reg[0] = '0;
    assign tag_reg[0] = tag_in;
    assign vld_reg[0] = in_valid;

    genvar s;
    generate
        for (s = 0; s < STAGES; s++) begin : g_stage
            logic [78:0] rem_c;
            logic [25:0] res_c;
            // two restoring root digits
            always_comb
            begin
                logic [28:0] win;
                logic [28:0] trial;
                rem_c = rem_reg[s];
                res_c = res_reg[s];
                for (int k = 0; k < STEPS; k++)
                begin
                    win = rem_c[78:50];
                    trial = win - {1'b0, res_c, 2'b01};
                    if (win >= {1'b0, res_c, 2'b01})
                    begin
                        rem_c = {trial[26:0], rem_c[49:0], 2'b00};
                        res_c = {res_c[24:0], 1'b1};
                    end
                    else
                    begin
                        rem_c = {win[26:0], rem_c[49:0], 2'b00};
                        res_c = {res_c[24:0], 1'b0};
                    end
                end
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[s+1] <= 1'b0;
                else
                    vld_reg[s+1] <= vld_reg[s];
            end
            always_ff @(posedge clk)
            begin
                rem_reg[s+1] <= rem_c;
                res_reg[s+1] <= res_c;
                tag_reg[s+1] <= tag_reg[s];
            end
        end
    endgenerate

    assign out_valid = vld_reg[STAGES];
    assign root = res_reg[STAGES][24:0];
    assign tag_out = tag_reg[STAGES];
endmodule

FILE: rtl/core/sros_lane.sv
// one sonar lane: projection, corridor test and distance
module sros_lane
#(
    parameter int LANE = 0,
    parameter int RANGE_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [RANGE_BITS-1:0]  range_mm,
    output logic                   out_valid,
    output sros_pkg::lane_res_t    res
);
    import sros_pkg::*;

    localparam lane_geom_t G = lane_geom(LANE);
    localparam logic [40:0] CORR_Q16 = 41'd300 << 16;
    localparam logic [40:0] AHEAD_Q16 = 41'd250 << 16;

    logic [40:0] fwd_reg, lat_reg;
    logic        v1_reg;

    // stage 1: projection products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        fwd_reg <= ({33'd0, G.fwd_off} << 16)
            + 41'(range_mm) * 41'(G.cos_q16);
        lat_reg <= ({33'd0, G.lat_off} << 16)
            + 41'(range_mm) * 41'(G.sin_q16);
    end

    // stage 2: tests, rounded front and scaled terms
    logic [40:0] fr;
    logic [32:0] f8, l8;
    assign fr = fwd_reg + 41'd32768;
    assign f8 = fwd_reg[40:8];
    assign l8 = lat_reg[40:8];

    logic        v2_reg, corr_reg, side_reg;
    logic [15:0] front_reg;
    logic [24:0] f8_reg, l8_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        corr_reg <= lat_reg < CORR_Q16;
        side_reg <= (fwd_reg > AHEAD_Q16) && (lat_reg != '0);
        front_reg <= (fr[40:16] > 25'hFFFF) ? NONE_MM : fr[31:16];
        f8_reg <= f8[24:0];
        l8_reg <= l8[24:0];
    end

    // stage 3: square each term
    logic        v3_reg, corr3_reg, side3_reg;
    logic [15:0] front3_reg;
    logic [49:0] ff_reg, ll_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end
    always_ff @(posedge clk)
    begin
        corr3_reg <= corr_reg;
        front3_reg <= front_reg;
        side3_reg <= side_reg;
        ff_reg <= 50'(f8_reg) * 50'(f8_reg);
        ll_reg <= 50'(l8_reg) * 50'(l8_reg);
    end

    // sum may exceed 50 bits only when far beyond saturation
    logic [50:0] sum;
    logic        big;
    assign sum = {1'b0, ff_reg} + {1'b0, ll_reg};
    assign big = sum[50];

    logic        sv;
    logic [24:0] root;
    logic [16:0] tag;
    sros_isqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .radicand  (sum[49:0]),
        .tag_in    ({corr3_reg, side3_reg & ~big, front3_reg[14:0]}),
        .out_valid (sv),
        .root      (root),
        .tag_out   (tag)
    );

    // front msb and big flag delayed alongside
    logic [12:0] fmsb_reg, big_reg;
    always_ff @(posedge clk)
    begin
        fmsb_reg <= {fmsb_reg[11:0], front3_reg[15]};
        big_reg <= {big_reg[11:0], big & side3_reg};
    end

    logic [25:0] rd;
    assign rd = {1'b0, root} + 26'd128;

    // final rounding and saturation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else
            out_valid <= sv;
    end
    always_ff @(posedge clk)
    begin
        res.in_corr <= tag[16];
        res.front <= {fmsb_reg[12], tag[14:0]};
        res.side_ok <= tag[15] | big_reg[12];
        res.is_right <= G.right_side;
        res.side_mm <= (big_reg[12] || rd[25:24] != 2'b00) ? NONE_MM : rd[23:8];
    end
endmodule

FILE: rtl/core/sros_merge.sv
// merge of lane results and drive command
module sros_merge
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  sros_pkg::lane_res_t [7:0]    lanes,
    input  sros_pkg::cfg_t               cfg,
    output logic                         done,
    output logic [15:0]                  front_mm,
    output logic [15:0]                  left_mm,
    output logic [15:0]                  right_mm,
    output logic signed [12:0]           linear_cmd,
    output logic signed [11:0]           angular_cmd
);
    import sros_pkg::*;

    // minimum per group
    logic [15:0] fmin, lmin, rmin;
    always_comb
    begin
        fmin = NONE_MM;
        lmin = NONE_MM;
        rmin = NONE_MM;
        for (int i = 0; i < NUM_LANES; i++) begin
            if (lanes[i].in_corr && lanes[i].front < fmin)
                fmin = lanes[i].front;
            if (lanes[i].side_ok && !lanes[i].is_right && lanes[i].side_mm < lmin)
                lmin = lanes[i].side_mm;
            if (lanes[i].side_ok && lanes[i].is_right && lanes[i].side_mm < rmin)
                rmin = lanes[i].side_mm;
        end
    end

    logic v1_reg;
    logic [15:0] f_reg, l_reg, r_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        f_reg <= fmin;
        l_reg <= lmin;
        r_reg <= rmin;
    end

    // drive command
    logic signed [17:0] lin;
    logic signed [11:0] ang;
    always_comb
    begin
        lin = $signed({2'b00, cfg.cruise_speed});
        if ({4'd0, cfg.slow_zone_mm} > f_reg)
            lin = $signed({2'b00, f_reg}) - $signed({7'd0, cfg.stop_offset_mm});
        ang = '0;
        if ({1'b0, r_reg} < {1'b0, l_reg} + 17'(cfg.side_margin_mm)
            && r_reg < {4'd0, cfg.side_near_mm})
            ang = $signed({1'b0, cfg.turn_rate});
        if ({1'b0, l_reg} < {1'b0, r_reg} + 17'(cfg.side_margin_mm)
            && l_reg < {4'd0, cfg.side_near_mm})
            ang = -$signed({1'b0, cfg.turn_rate});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        front_mm <= f_reg;
        left_mm <= l_reg;
        right_mm <= r_reg;
        linear_cmd <= lin[12:0];
        angular_cmd <= ang;
    end

    // cruise when the front is clear, no turn without a near side
    a_lin_clear: assert property (@(posedge clk) disable iff (!rst_n)
        done && front_mm >= {4'd0, cfg.slow_zone_mm} |-> linear_cmd ==
        $signed({1'b0, cfg.cruise_speed}))
        else $error("linear command wrong when clear");
    a_done_follow: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |=> done)
        else $error("result lost in merge");
    a_ang_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && left_mm >= {4'd0, cfg.side_near_mm}
        && right_mm >= {4'd0, cfg.side_near_mm} |-> angular_cmd == 12'sd0)
        else $error("turn without near side");
endmodule

FILE: rtl/core/sonar_ring_obstacle_steering.sv
// top level of the sonar ring obstacle steering block
// One scan is taken per cycle (busy never rises) and its result appears on the
// result ports with done high once it has passed projection, tests, squares,
// a 13-stage square root, the lane output register and two merge stages.
// Results cannot be held off, so every scan yields exactly one done pulse.
module sonar_ring_obstacle_steering
#(
    parameter int RANGE_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [15:0]          range_0,
    input  logic [15:0]          range_1,
    input  logic [15:0]          range_2,
    input  logic [15:0]          range_3,
    input  logic [15:0]          range_4,
    input  logic [15:0]          range_5,
    input  logic [15:0]          range_6,
    input  logic [15:0]          range_7,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [11:0]          cfg_data,
    output logic                 done,
    output logic [15:0]          front_mm,
    output logic [15:0]          left_mm,
    output logic [15:0]          right_mm,
    output logic signed [12:0]   linear_cmd,
    output logic signed [11:0]   angular_cmd
);
    import sros_pkg::*;

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;

    // configuration registers
    cfg_t cfg_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= '{12'd1000, 12'd1250, 11'd850, 12'd1000, 10'd100, 11'd750};
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_CRUISE: cfg_reg.cruise_speed <= cfg_data;
                REG_SLOW:   cfg_reg.slow_zone_mm <= cfg_data;
                REG_STOP:   cfg_reg.stop_offset_mm <= cfg_data[10:0];
                REG_NEAR:   cfg_reg.side_near_mm <= cfg_data;
                REG_MARGIN: cfg_reg.side_margin_mm <= cfg_data[9:0];
                REG_TURN:   cfg_reg.turn_rate <= cfg_data[10:0];
                default:    ;
            endcase
        end
    end

    logic [15:0] ranges [NUM_LANES];
    assign ranges[0] = range_0;
    assign ranges[1] = range_1;
    assign ranges[2] = range_2;
    assign ranges[3] = range_3;
    assign ranges[4] = range_4;
    assign ranges[5] = range_5;
    assign ranges[6] = range_6;
    assign ranges[7] = range_7;

    // eight lanes side by side
    lane_res_t [7:0] lres;
    logic [7:0] lvld;
    genvar i;
    generate
        for (i = 0; i < NUM_LANES; i++) begin : g_lane
            sros_lane #(.LANE(i), .RANGE_BITS(RANGE_BITS)) u_lane
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (start),
                .range_mm  (ranges[i][RANGE_BITS-1:0]),
                .out_valid (lvld[i]),
                .res       (lres[i])
            );
        end
    endgenerate

    sros_merge u_merge
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (lvld[0]),
        .lanes       (lres),
        .cfg         (cfg_reg),
        .done        (done),
        .front_mm    (front_mm),
        .left_mm     (left_mm),
        .right_mm    (right_mm),
        .linear_cmd  (linear_cmd),
        .angular_cmd (angular_cmd)
    );

    // lanes stay in lock step
    a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        lvld == 8'h00 || lvld == 8'hFF)
        else $error("lanes out of step");
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        done && linear_cmd < 13'sd0 |-> front_mm < {5'd0, cfg_reg.stop_offset_mm})
        else $error("reverse without obstacle");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
endmodule
